@@ design/lowest_free_id_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lowest-free-id allocator
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFIA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFIA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lfia_pkg.sv @@
// ----------------------------------------------------------------------------
// lfia_pkg
// Types, constants and search functions of the lowest-free-id allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfia_pkg;

	// Id space and the layout of the presence bitmap in memory words.
	localparam int VALUE_SPACE = 4096;
	localparam int VAL_W       = 32;
	localparam int FREE_W      = 12;
	localparam int MAP_W       = $clog2(VALUE_SPACE);
	localparam int LF_W        = MAP_W + 1;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int NWORDS      = VALUE_SPACE / WORD_W;
	localparam int WADDR_W     = $clog2(NWORDS);

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_ALLOC   = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_kind_t;

	// One input item.
	typedef struct packed {
		logic [1:0]       req_type;
		logic [VAL_W-1:0] value;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [FREE_W-1:0] free_id;
		logic              full_res;
	} res_t;

	// Index of the lowest zero bit of a bitmap word (zero when there is none).
	function automatic logic [BIT_W-1:0] first_zero_bit(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	// Index of the lowest word that is not full (zero when there is none).
	function automatic logic [WADDR_W-1:0] first_open_word(input logic [NWORDS-1:0] f);
		logic [WADDR_W-1:0] idx;
		idx = '0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (!f[i]) begin
				idx = WADDR_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ design/lfia_ram.sv @@
// ----------------------------------------------------------------------------
// lfia_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/lowest_free_id_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_unit
// Presence bitmap over the id space with a running lowest-free-id register.
// ----------------------------------------------------------------------------
// The bitmap lives in a 64 x 64-bit RAM with a registered read, backed by one
// valid bit and one full bit per word in flip-flops; a clear item drops all of
// them together, so no clearing pass is needed. A load, or an allocate while
// ids remain, is one read-modify-write of a bitmap word, and that is all when
// the next free id sits in the same word. When the word fills up, the full
// bits pick the next open word and a second RAM read finds its free bit. A
// release of an id at or above the current lowest free id writes its word
// first and then allocates. A result waits in an output register, and a new
// item is taken while it does.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lowest_free_id_allocator_unit_assert.svh"

module lowest_free_id_allocator_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire lfia_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output lfia_pkg::res_t     res
);

	import lfia_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MOD  = 5'b00010,
		S_ARD  = 5'b00100,
		S_FIND = 5'b01000,
		S_FZ   = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [1:0]          op_q, op_d;
	logic [MAP_W-1:0]    v_q, v_d;
	logic [WADDR_W-1:0]  widx_q, widx_d;
	logic [LF_W-1:0]     lf_q, lf_d;
	logic [NWORDS-1:0]   valid_q, valid_d;
	logic [NWORDS-1:0]   full_q, full_d;
	logic                res_valid_q;
	res_t                res_q, res_d;
	logic                res_load;
	logic                res_free;

	logic                ram_we;
	logic                ram_re;
	logic [WADDR_W-1:0]  ram_raddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [WORD_W-1:0]   ram_rdata;

	logic [WORD_W-1:0]   word_cur;
	logic [WORD_W-1:0]   new_word;
	logic [WORD_W-1:0]   bit_mask;
	logic [BIT_W-1:0]    bit_pos;
	logic                in_range;
	logic                lf_full;

	// Bitmap word store.
	lfia_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NWORDS)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(widx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared decode of the current word and the bit being touched.
	assign in_range  = req.value < VAL_W'(VALUE_SPACE);
	assign lf_full   = lf_q == LF_W'(VALUE_SPACE);
	assign word_cur  = valid_q[widx_q] ? ram_rdata : '0;
	assign bit_pos   = (op_q == REQ_ALLOC) ? lf_q[BIT_W-1:0] : v_q[BIT_W-1:0];
	assign bit_mask  = WORD_W'(1) << bit_pos;
	assign res_free  = !res_valid_q || res_ready;
	assign req_ready = state_q == S_IDLE;
	assign ram_wdata = new_word;

	// Sequencer: accept, read-modify-write, and the forward scan.
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		v_d       = v_q;
		widx_d    = widx_q;
		lf_d      = lf_q;
		valid_d   = valid_q;
		full_d    = full_q;
		ram_re    = 1'b0;
		ram_raddr = widx_q;
		ram_we    = 1'b0;
		new_word  = word_cur;
		res_load  = 1'b0;
		res_d     = '0;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.req_type)
						REQ_LOAD: begin
							if (in_range) begin
								op_d      = REQ_LOAD;
								v_d       = req.value[MAP_W-1:0];
								widx_d    = req.value[MAP_W-1:BIT_W];
								ram_re    = 1'b1;
								ram_raddr = req.value[MAP_W-1:BIT_W];
								state_d   = S_MOD;
							end
						end
						REQ_ALLOC: begin
							op_d      = REQ_ALLOC;
							widx_d    = lf_q[MAP_W-1:BIT_W];
							ram_re    = 1'b1;
							ram_raddr = lf_q[MAP_W-1:BIT_W];
							state_d   = S_MOD;
						end
						REQ_RELEASE: begin
							if (in_range) begin
								op_d      = REQ_RELEASE;
								v_d       = req.value[MAP_W-1:0];
								widx_d    = req.value[MAP_W-1:BIT_W];
								ram_re    = 1'b1;
								ram_raddr = req.value[MAP_W-1:BIT_W];
							end else begin
								op_d      = REQ_ALLOC;
								widx_d    = lf_q[MAP_W-1:BIT_W];
								ram_re    = 1'b1;
								ram_raddr = lf_q[MAP_W-1:BIT_W];
							end
							state_d = S_MOD;
						end
						REQ_CLEAR: begin
							valid_d = '0;
							full_d  = '0;
							lf_d    = '0;
						end
						default: begin
						end
					endcase
				end
			end

			S_MOD: begin
				case (op_q)
					REQ_LOAD: begin
						new_word        = word_cur | bit_mask;
						ram_we          = 1'b1;
						valid_d[widx_q] = 1'b1;
						full_d[widx_q]  = &new_word;
						if ({1'b0, v_q} == lf_q) begin
							if (!(&new_word)) begin
								lf_d    = {1'b0, widx_q, first_zero_bit(new_word)};
								state_d = S_IDLE;
							end else begin
								state_d = S_FIND;
							end
						end else begin
							state_d = S_IDLE;
						end
					end
					REQ_ALLOC: begin
						if (res_free) begin
							res_load = 1'b1;
							if (lf_full) begin
								res_d.full_res = 1'b1;
								state_d        = S_IDLE;
							end else begin
								res_d.free_id   = lf_q[FREE_W-1:0];
								new_word        = word_cur | bit_mask;
								ram_we          = 1'b1;
								valid_d[widx_q] = 1'b1;
								full_d[widx_q]  = &new_word;
								if (!(&new_word)) begin
									lf_d    = {1'b0, widx_q, first_zero_bit(new_word)};
									state_d = S_IDLE;
								end else begin
									state_d = S_FIND;
								end
							end
						end
					end
					REQ_RELEASE: begin
						// Releasing below the lowest free id hands that id straight
						// back, so the map and the register end up unchanged.
						if ({1'b0, v_q} < lf_q) begin
							if (res_free) begin
								res_load      = 1'b1;
								res_d.free_id = FREE_W'(v_q);
								state_d       = S_IDLE;
							end
						end else begin
							new_word        = word_cur & ~bit_mask;
							ram_we          = 1'b1;
							valid_d[widx_q] = 1'b1;
							full_d[widx_q]  = 1'b0;
							state_d         = S_ARD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end

			S_ARD: begin
				// The released word is written; now read the allocation word.
				op_d      = REQ_ALLOC;
				widx_d    = lf_q[MAP_W-1:BIT_W];
				ram_re    = 1'b1;
				ram_raddr = lf_q[MAP_W-1:BIT_W];
				state_d   = S_MOD;
			end

			S_FIND: begin
				if (&full_q) begin
					lf_d    = LF_W'(VALUE_SPACE);
					state_d = S_IDLE;
				end else begin
					widx_d    = first_open_word(full_q);
					ram_re    = 1'b1;
					ram_raddr = first_open_word(full_q);
					state_d   = S_FZ;
				end
			end

			S_FZ: begin
				lf_d    = {1'b0, widx_q, first_zero_bit(word_cur)};
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lf_q        <= '0;
			valid_q     <= '0;
			full_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lf_q    <= lf_d;
			valid_q <= valid_d;
			full_q  <= full_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Item payload and the result register.
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		v_q    <= v_d;
		widx_q <= widx_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The lowest free id never runs past the id space.
	`LFIA_ASSERT_NOW(a_lf_bound, 1'b1, lf_q <= LF_W'(VALUE_SPACE), "lowest free id out of range")

	// A full result is only produced when no id is free.
	`LFIA_ASSERT_NOW(a_full_res, res_load && res_d.full_res, lf_full && (&full_q),
		"full result while ids remain")

	// The RAM is never read and written in the same cycle.
	`LFIA_ASSERT_NOW(a_ram_port, ram_we, !ram_re, "RAM read overlaps a write")

	// A clear item has emptied the store in the cycle after it is taken.
	`LFIA_ASSERT_NEXT(a_clear, req_valid && req_ready && (req.req_type == REQ_CLEAR),
		(lf_q == '0) && (valid_q == '0) && (full_q == '0), "clear did not empty the store")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for lowest_free_id_allocator_unit
// Sends load, allocate, release and clear items through the valid/ready
// request channel and predicts each granted id with a bitmap model kept
// alongside. Each result is checked field by field, in order, against the
// oldest prediction. Both sides idle at random, and the result side also
// holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------

module tb;
	import lfia_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 9;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int IDLE_PCT      = 19;
	localparam int RANDOM_ITEMS  = 500;
	localparam int QUIET_ITEMS   = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int REPORT_LIMIT  = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;

	// Bitmap of ids in use and the running lowest free id, as the block keeps them.
	bit              id_used [VALUE_SPACE];
	logic [LF_W-1:0] next_free;
	res_t            pending_grants[$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned sink_hold_req;
	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned items_sent;
	int unsigned grants_checked;
	int unsigned full_grants;
	int unsigned kind_count [4];

	lowest_free_id_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_grants.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Move the lowest free id forward past every id in use.
	function automatic void skip_used_ids();
		while (next_free < LF_W'(VALUE_SPACE) && id_used[next_free[MAP_W-1:0]]) begin
			next_free++;
		end
	endfunction

	// Hand out the lowest free id, or flag the store as full.
	function automatic res_t grant_lowest_free();
		res_t r;
		if (next_free >= LF_W'(VALUE_SPACE)) begin
			r.free_id  = '0;
			r.full_res = 1'b1;
		end else begin
			r.free_id  = next_free[FREE_W-1:0];
			r.full_res = 1'b0;
			id_used[next_free[MAP_W-1:0]] = 1'b1;
			next_free++;
			skip_used_ids();
		end
		return r;
	endfunction

	// Update the bitmap for one accepted item and queue the grant it causes.
	function automatic void track_request(input req_t item);
		logic in_range;
		in_range = item.value < VAL_W'(VALUE_SPACE);
		case (req_kind_t'(item.req_type))
			REQ_LOAD: begin
				if (in_range) begin
					id_used[item.value[MAP_W-1:0]] = 1'b1;
					if (item.value == VAL_W'(next_free)) begin
						skip_used_ids();
					end
				end
			end
			REQ_ALLOC: begin
				pending_grants.push_back(grant_lowest_free());
			end
			REQ_RELEASE: begin
				if (in_range) begin
					id_used[item.value[MAP_W-1:0]] = 1'b0;
					if (item.value < VAL_W'(next_free)) begin
						next_free = LF_W'(item.value);
					end
				end
				pending_grants.push_back(grant_lowest_free());
			end
			default: begin
				foreach (id_used[i]) begin
					id_used[i] = 1'b0;
				end
				next_free = '0;
			end
		endcase
	endfunction

	// Offer one item, with a random gap first, and wait until it is taken.
	// Valid is left high on return so back-to-back items keep it asserted.
	task automatic send_item(input req_kind_t kind, input logic [VAL_W-1:0] value);
		req_t item;
		item.req_type = kind;
		item.value    = value;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do begin
			@(posedge clk);
		end while (!req_ready);
		track_request(item);
		items_sent++;
		kind_count[kind]++;
	endtask

	// Pick an id that is likely to matter: mostly near the lowest free id.
	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 50) begin
			return VAL_W'(next_free) + VAL_W'($urandom_range(96));
		end else if (sel < 65) begin
			return VAL_W'($urandom_range(int'(next_free)));
		end else if (sel < 85) begin
			return VAL_W'($urandom_range(VALUE_SPACE - 1));
		end else if (sel < 90) begin
			return VAL_W'(VALUE_SPACE - 1 - $urandom_range(3));
		end
		return $urandom();
	endfunction

	// Pick a request kind, weighted toward the ones that give results.
	function automatic req_kind_t pick_kind();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 32) begin
			return REQ_LOAD;
		end else if (sel < 63) begin
			return REQ_ALLOC;
		end else if (sel < 98) begin
			return REQ_RELEASE;
		end
		return REQ_CLEAR;
	endfunction

	// Log a result that disagrees with the prediction.
	task automatic report_mismatch(input string what, input res_t want, input res_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("[%0t] %s: expected free_id=%0d full_res=%0b, got free_id=%0d full_res=%0b",
				$time, what, want.free_id, want.full_res, got.free_id, got.full_res);
		end
	endtask

	// Result sink: random ready, with a long hold-off when a test asks for one.
	initial begin : result_sink
		int unsigned hold_len;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req != 0) begin
				hold_len      = sink_hold_req;
				sink_hold_req = 0;
				res_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
			end
			res_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each accepted result with the oldest pending grant.
	always @(posedge clk) begin : grant_checker
		res_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1) begin
			grants_checked++;
			if (pending_grants.size() == 0) begin
				want = '0;
				report_mismatch("Result with no item pending", want, res);
			end else begin
				want = pending_grants.pop_front();
				if (want.full_res) begin
					full_grants++;
				end
				if (res.free_id !== want.free_id || res.full_res !== want.full_res) begin
					report_mismatch("Grant mismatch", want, res);
				end
			end
		end
	end

	// Field extremes, every request kind and the simple corner cases.
	task automatic test_directed();
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_LOAD, 32'd2);
		send_item(REQ_LOAD, 32'd1);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_LOAD, 32'd1);
		send_item(REQ_LOAD, VAL_W'(VALUE_SPACE));
		send_item(REQ_LOAD, 32'hFFFF_FFFF);
		send_item(REQ_LOAD, VAL_W'(VALUE_SPACE - 1));
		send_item(REQ_RELEASE, VAL_W'(VALUE_SPACE));
		send_item(REQ_RELEASE, 32'hFFFF_FFFF);
		send_item(REQ_RELEASE, 32'd2);
		send_item(REQ_RELEASE, 32'd100);
		send_item(REQ_RELEASE, VAL_W'(VALUE_SPACE - 1));
		send_item(REQ_RELEASE, 32'd0);
		send_item(REQ_ALLOC, 32'hFFFF_FFFF);
		send_item(REQ_CLEAR, 32'hFFFF_FFFF);
		send_item(REQ_ALLOC, 32'h5555_5555);
		send_item(REQ_LOAD, 32'hAAAA_AAAA);
		send_item(REQ_RELEASE, 32'h0000_0AAA);
		send_item(REQ_LOAD, 32'h0000_0555);
		send_item(REQ_CLEAR, 32'd0);
		send_item(REQ_ALLOC, 32'd0);
	endtask

	// Runs of used ids that span several bitmap words, so scans cross words.
	task automatic test_word_runs();
		send_item(REQ_CLEAR, 32'd0);
		for (int i = 1; i <= 200; i++) begin
			send_item(REQ_LOAD, VAL_W'(i));
		end
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_RELEASE, 32'd64);
		send_item(REQ_RELEASE, 32'd63);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_LOAD, 32'd203);
		send_item(REQ_LOAD, 32'd202);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_RELEASE, 32'd127);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_CLEAR, 32'd0);
	endtask

	// Fill every id in shuffled order, then allocate and release while full.
	task automatic test_full_store();
		int unsigned fill_order [VALUE_SPACE];
		int unsigned pick;
		int unsigned swap;
		foreach (fill_order[i]) begin
			fill_order[i] = i;
		end
		for (int i = VALUE_SPACE - 1; i > 0; i--) begin
			pick             = $urandom_range(i);
			swap             = fill_order[i];
			fill_order[i]    = fill_order[pick];
			fill_order[pick] = swap;
		end
		send_item(REQ_CLEAR, 32'd0);
		foreach (fill_order[i]) begin
			send_item(REQ_LOAD, VAL_W'(fill_order[i]));
		end
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_ALLOC, 32'hFFFF_FFFF);
		send_item(REQ_RELEASE, VAL_W'(VALUE_SPACE));
		send_item(REQ_RELEASE, 32'd1234);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_RELEASE, VAL_W'(VALUE_SPACE - 1));
		send_item(REQ_RELEASE, 32'd0);
		send_item(REQ_LOAD, 32'd0);
		send_item(REQ_ALLOC, 32'd0);
		send_item(REQ_CLEAR, 32'd0);
	endtask

	// Hold the result side off while items keep coming, so the block stalls.
	task automatic test_backpressure();
		tx_idle_pct   = 0;
		sink_hold_req = HOLD_CYCLES;
		for (int i = 0; i < 30; i++) begin
			send_item((i % 3 == 2) ? REQ_LOAD : REQ_ALLOC, pick_value());
		end
		tx_idle_pct = IDLE_PCT;
	endtask

	// Random mix; the first stretch runs with no idling on either side.
	task automatic test_random();
		req_kind_t kind;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			tx_idle_pct = (i < QUIET_ITEMS) ? 0 : IDLE_PCT;
			rx_idle_pct = (i < QUIET_ITEMS) ? 0 : IDLE_PCT;
			kind = pick_kind();
			send_item(kind, pick_value());
		end
	endtask

	initial begin : stimulus
		tx_idle_pct   = IDLE_PCT;
		rx_idle_pct   = IDLE_PCT;
		sink_hold_req = 0;
		next_free     = '0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_word_runs();
		test_full_store();
		test_backpressure();
		test_random();

		req_valid <= 1'b0;
		while (pending_grants.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d loads, %0d allocates, %0d releases, %0d clears.",
			items_sent, kind_count[REQ_LOAD], kind_count[REQ_ALLOC],
			kind_count[REQ_RELEASE], kind_count[REQ_CLEAR]);
		$display("Checked %0d granted ids, %0d of them with the store full; %0d mismatches.",
			grants_checked, full_grants, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ lowest_free_id_allocator_unit.f @@
+incdir+design
design/lfia_pkg.sv
design/lfia_ram.sv
design/lowest_free_id_allocator_unit.sv
verif/tb.sv
